// ===== sv/cbez_pkg.sv =====
// Shared types, stage enables and rounding helpers for the cubic Bezier evaluator.
package cbez_pkg;

  localparam int unsigned TW = 17;  // t and u, unsigned Q1.16 within 0..1

  typedef logic        [TW-1:0] param_t;
  typedef logic signed [32:0]   coord_t;  // Q15.16 coordinate, room for exact negation
  typedef logic signed [26:0]   wt_t;     // Bernstein weight, Q.24
  typedef logic signed [59:0]   prod_t;   // weight times coordinate, Q.40
  typedef logic signed [61:0]   acc_t;    // sum of four products
  typedef logic signed [35:0]   vsum_t;   // derivative weight before rounding, Q.32
  typedef logic        [32:0]   sq_t;     // product of two parameters, Q.32
  typedef logic        [48:0]   cube_t;   // product of three parameters, Q.48
  typedef logic        [50:0]   cube3_t;  // three times a cube term

  localparam vsum_t  VelHalf = 36'sd128;       // half LSB at Q.24 from Q.32
  localparam cube3_t PosHalf = 51'd8388608;    // half LSB at Q.24 from Q.48
  localparam acc_t   AccHalf = 62'sd8388608;   // half LSB at Q.16 from Q.40

  typedef struct packed {
    logic sq;    // load square terms
    logic cube;  // load cube terms and derivative weights
    logic wgt;   // load rounded weights
  } wgt_en_t;

  typedef struct packed {
    logic prod;  // load products
    logic sum;   // load sum
    logic res;   // load rounded, saturated result
  } cmb_en_t;

  // floor(v / 2^8 + 1/2); the result always fits 27 signed bits
  function automatic wt_t rnd_vel(input vsum_t v);
    vsum_t b;
    b = v + VelHalf;
    return b[34:8];
  endfunction

  // floor(v / 2^24 + 1/2) for a nonnegative cube term
  function automatic wt_t rnd_pos(input cube3_t v);
    cube3_t b;
    b = v + PosHalf;
    return b[50:24];
  endfunction

  // three times a cube term, by shift and add
  function automatic cube3_t times3(input cube_t v);
    return {2'b00, v} + {1'b0, v, 1'b0};
  endfunction

endpackage

// ===== sv/cbez_weights.sv =====
// Bernstein weight pipeline: squares, cubes, then rounded position and derivative weights.
module cbez_weights (
  input  logic                    clk_i,
  input  cbez_pkg::wgt_en_t       en_i,
  input  cbez_pkg::param_t        t_i,
  input  cbez_pkg::param_t        u_i,
  output cbez_pkg::wt_t     [3:0] wgt_pos_o,
  output cbez_pkg::wt_t     [3:0] wgt_vel_o
);

  cbez_pkg::sq_t    uu_q, ut_q, tt_q;
  cbez_pkg::param_t t1_q, u1_q;
  cbez_pkg::sq_t    uu_d, ut_d, tt_d;

  cbez_pkg::cube_t  uuu_q, uut_q, utt_q, ttt_q;
  cbez_pkg::cube_t  uuu_d, uut_d, utt_d, ttt_d;
  cbez_pkg::wt_t    [3:0] vel_q, vel_d;

  cbez_pkg::wt_t    [3:0] pos_q, pos_d, velw_q;

  logic        [35:0] uu3, ut6, tt3;
  cbez_pkg::vsum_t    v0, v1, v2, v3;

  // squares
  assign uu_d = cbez_pkg::sq_t'(u_i) * cbez_pkg::sq_t'(u_i);
  assign ut_d = cbez_pkg::sq_t'(u_i) * cbez_pkg::sq_t'(t_i);
  assign tt_d = cbez_pkg::sq_t'(t_i) * cbez_pkg::sq_t'(t_i);

  always_ff @(posedge clk_i) begin
    if (en_i.sq) begin
      uu_q <= uu_d;
      ut_q <= ut_d;
      tt_q <= tt_d;
      t1_q <= t_i;
      u1_q <= u_i;
    end
  end

  // cubes
  assign uuu_d = cbez_pkg::cube_t'(uu_q) * cbez_pkg::cube_t'(u1_q);
  assign uut_d = cbez_pkg::cube_t'(uu_q) * cbez_pkg::cube_t'(t1_q);
  assign utt_d = cbez_pkg::cube_t'(tt_q) * cbez_pkg::cube_t'(u1_q);
  assign ttt_d = cbez_pkg::cube_t'(tt_q) * cbez_pkg::cube_t'(t1_q);

  // derivative weights from the squares
  assign uu3 = {3'b000, uu_q} + {2'b00, uu_q, 1'b0};
  assign ut6 = {1'b0, ut_q, 2'b00} + {2'b00, ut_q, 1'b0};
  assign tt3 = {3'b000, tt_q} + {2'b00, tt_q, 1'b0};

  assign v0 = -$signed(uu3);
  assign v1 = $signed(uu3) - $signed(ut6);
  assign v2 = $signed(ut6) - $signed(tt3);
  assign v3 = $signed(tt3);

  assign vel_d[0] = cbez_pkg::rnd_vel(v0);
  assign vel_d[1] = cbez_pkg::rnd_vel(v1);
  assign vel_d[2] = cbez_pkg::rnd_vel(v2);
  assign vel_d[3] = cbez_pkg::rnd_vel(v3);

  always_ff @(posedge clk_i) begin
    if (en_i.cube) begin
      uuu_q <= uuu_d;
      uut_q <= uut_d;
      utt_q <= utt_d;
      ttt_q <= ttt_d;
      vel_q <= vel_d;
    end
  end

  // rounded position weights
  assign pos_d[0] = cbez_pkg::rnd_pos({2'b00, uuu_q});
  assign pos_d[1] = cbez_pkg::rnd_pos(cbez_pkg::times3(uut_q));
  assign pos_d[2] = cbez_pkg::rnd_pos(cbez_pkg::times3(utt_q));
  assign pos_d[3] = cbez_pkg::rnd_pos({2'b00, ttt_q});

  always_ff @(posedge clk_i) begin
    if (en_i.wgt) begin
      pos_q  <= pos_d;
      velw_q <= vel_q;
    end
  end

  assign wgt_pos_o = pos_q;
  assign wgt_vel_o = velw_q;

endmodule

// ===== sv/cbez_combine.sv =====
// Weighted sum of four control points with rounding and saturation to Q15.16.
module cbez_combine (
  input  logic                       clk_i,
  input  cbez_pkg::cmb_en_t          en_i,
  input  cbez_pkg::wt_t        [3:0] wgt_i,
  input  cbez_pkg::coord_t     [3:0] pnt_i,
  output logic signed         [31:0] res_o
);

  cbez_pkg::prod_t prod_q [4];
  cbez_pkg::prod_t prod_d [4];
  cbez_pkg::acc_t  acc_q, acc_d, acc_r;
  logic signed [37:0] rnd;
  logic signed [31:0] res_q, res_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = cbez_pkg::prod_t'($signed(wgt_i[i])) * cbez_pkg::prod_t'($signed(pnt_i[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
  end

  assign acc_d = (62'(prod_q[0]) + 62'(prod_q[1])) + (62'(prod_q[2]) + 62'(prod_q[3]));

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      acc_q <= acc_d;
    end
  end

  assign acc_r = acc_q + cbez_pkg::AccHalf;
  assign rnd   = acc_r[61:24];

  // clamp to the signed 32-bit range
  always_comb begin
    if (!rnd[37] && (|rnd[36:31])) begin
      res_d = 32'sh7FFFFFFF;
    end else if (rnd[37] && !(&rnd[36:31])) begin
      res_d = 32'sh80000000;
    end else begin
      res_d = rnd[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.res) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/cubic_bezier_pos_vel_eval.sv =====
// Top level: cubic Bezier position and derivative evaluator, 2-D, Q15.16.
// A request passes through the capture, square, cube, weight, product, sum and result stages.
// Throughput: one request per cycle; stages hold per-stage valid bits, so bubbles
// close up and a stall on the output propagates back only through full stages.
// Reset clears the valid bits only; datapath registers are not reset.
module cubic_bezier_pos_vel_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] start_pos_x_i,
  input  logic signed [31:0] start_pos_y_i,
  input  logic signed [31:0] start_vel_x_i,
  input  logic signed [31:0] start_vel_y_i,
  input  logic signed [31:0] end_pos_x_i,
  input  logic signed [31:0] end_pos_y_i,
  input  logic signed [31:0] end_vel_x_i,
  input  logic signed [31:0] end_vel_y_i,
  input  logic signed [17:0] curve_param_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic               param_error_o
);

  localparam int unsigned NStg  = 7;
  localparam int unsigned NDly  = 4;   // capture plus three weight stages
  localparam int unsigned LastS = NStg - 1;

  logic [NStg-1:0] vld_q, vld_d, en;
  logic [NStg-1:0] err_q;

  cbez_pkg::param_t t_d, u_d, t_q, u_q;
  logic             bad;

  cbez_pkg::coord_t [3:0] px_d, py_d;
  cbez_pkg::coord_t [3:0] px_q [NDly];
  cbez_pkg::coord_t [3:0] py_q [NDly];

  cbez_pkg::wgt_en_t     wen;
  cbez_pkg::cmb_en_t     cen;
  cbez_pkg::wt_t   [3:0] wgt_pos, wgt_vel;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[LastS] = !vld_q[LastS] || !stall_i;
    for (int k = LastS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];

  always_comb begin
    vld_d[0] = valid_i;
    for (int k = 1; k < NStg; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  // t outside 0..1 zeroes t and u, which zeroes every weight
  assign bad = curve_param_i[17] || (curve_param_i[16] && (|curve_param_i[15:0]));
  assign t_d = bad ? '0 : curve_param_i[16:0];
  assign u_d = bad ? '0 : cbez_pkg::param_t'(17'd65536 - curve_param_i[16:0]);

  assign px_d[0] = cbez_pkg::coord_t'(start_pos_x_i);
  assign px_d[1] = cbez_pkg::coord_t'(start_vel_x_i);
  assign px_d[2] = -cbez_pkg::coord_t'(end_vel_x_i);
  assign px_d[3] = cbez_pkg::coord_t'(end_pos_x_i);
  assign py_d[0] = cbez_pkg::coord_t'(start_pos_y_i);
  assign py_d[1] = cbez_pkg::coord_t'(start_vel_y_i);
  assign py_d[2] = -cbez_pkg::coord_t'(end_vel_y_i);
  assign py_d[3] = cbez_pkg::coord_t'(end_pos_y_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t_q      <= t_d;
      u_q      <= u_d;
      px_q[0]  <= px_d;
      py_q[0]  <= py_d;
      err_q[0] <= bad;
    end
    for (int k = 1; k < NDly; k++) begin
      if (en[k]) begin
        px_q[k] <= px_q[k-1];
        py_q[k] <= py_q[k-1];
      end
    end
    for (int k = 1; k < NStg; k++) begin
      if (en[k]) begin
        err_q[k] <= err_q[k-1];
      end
    end
  end

  assign wen.sq   = en[1];
  assign wen.cube = en[2];
  assign wen.wgt  = en[3];
  assign cen.prod = en[4];
  assign cen.sum  = en[5];
  assign cen.res  = en[6];

  cbez_weights u_weights (
    .clk_i     (clk_i),
    .en_i      (wen),
    .t_i       (t_q),
    .u_i       (u_q),
    .wgt_pos_o (wgt_pos),
    .wgt_vel_o (wgt_vel)
  );

  cbez_combine u_pos_x (
    .clk_i (clk_i),
    .en_i  (cen),
    .wgt_i (wgt_pos),
    .pnt_i (px_q[NDly-1]),
    .res_o (pos_x_o)
  );

  cbez_combine u_pos_y (
    .clk_i (clk_i),
    .en_i  (cen),
    .wgt_i (wgt_pos),
    .pnt_i (py_q[NDly-1]),
    .res_o (pos_y_o)
  );

  cbez_combine u_vel_x (
    .clk_i (clk_i),
    .en_i  (cen),
    .wgt_i (wgt_vel),
    .pnt_i (px_q[NDly-1]),
    .res_o (vel_x_o)
  );

  cbez_combine u_vel_y (
    .clk_i (clk_i),
    .en_i  (cen),
    .wgt_i (wgt_vel),
    .pnt_i (py_q[NDly-1]),
    .res_o (vel_y_o)
  );

  assign valid_o       = vld_q[LastS];
  assign param_error_o = err_q[LastS];

endmodule
